// File: hw/rtl/u8tc_pkg.sv
// Shared constants and the Windows-1252 mapping for the UTF-8 transcoder.
package u8tc_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned CODE_W = 16;
    localparam int unsigned PEND_W = 2;

    localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;
    localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
    localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
    localparam logic [CODE_W-1:0] QMARK      = 16'h003F;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;

    typedef enum logic [0:0] {
        FMT_UTF16  = 1'b0,
        FMT_CP1252 = 1'b1
    } t_fmt;

    function automatic logic [CODE_W-1:0] to_cp1252(input logic [CODE_W-1:0] u);
        logic [CODE_W-1:0] r;
        case (u)
            16'h20AC: r = 16'h0080;
            16'h201A: r = 16'h0082;
            16'h0192: r = 16'h0083;
            16'h201E: r = 16'h0084;
            16'h2026: r = 16'h0085;
            16'h2020: r = 16'h0086;
            16'h2021: r = 16'h0087;
            16'h02C6: r = 16'h0088;
            16'h2030: r = 16'h0089;
            16'h0160: r = 16'h008A;
            16'h2039: r = 16'h008B;
            16'h0152: r = 16'h008C;
            16'h017D: r = 16'h008E;
            16'h2018: r = 16'h0091;
            16'h2019: r = 16'h0092;
            16'h201C: r = 16'h0093;
            16'h201D: r = 16'h0094;
            16'h2022: r = 16'h0095;
            16'h2013: r = 16'h0096;
            16'h2014: r = 16'h0097;
            16'h02DC: r = 16'h0098;
            16'h2122: r = 16'h0099;
            16'h0161: r = 16'h009A;
            16'h203A: r = 16'h009B;
            16'h0153: r = 16'h009C;
            16'h017E: r = 16'h009E;
            16'h0178: r = 16'h009F;
            default: begin
                if (u < 16'h0080 || (u >= 16'h00A0 && u < 16'h0100)) begin
                    r = {8'h00, u[7:0]};
                end else begin
                    r = QMARK;
                end
            end
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/utf8_to_bmp_or_cp1252_transcoder_core.sv
// UTF-8 byte stream decoder to BMP code units or Windows-1252 bytes.
//
//  channel  direction  handshake                     payload
//  -------  ---------  ----------------------------  ---------------------------
//  in       sink       i_in_valid / o_in_stall       i_in_byte
//  out      source     o_out_valid / i_out_stall     o_code_out, o_bad_lead
//  cfg      sink       i_cfg_valid / o_cfg_ready     i_cfg_output_format
//
//  One byte per cycle sustained while the output is not stalled; each byte
//  is held in the input register and its result lands in the output register.
//  Decode, the sequence state update and the 27-way table compare sit in
//  one combinational path between the two registers.
//  Synchronous active-low reset clears the valids, the sequence state and the
//  format register. A stalled output holds; the input register still drains
//  bytes that produce no result.
module utf8_to_bmp_or_cp1252_transcoder_core
    import u8tc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [CODE_W-1:0] o_code_out,
    output logic              o_bad_lead,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic              i_cfg_output_format
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [CODE_W-1:0] r_code;
    logic              r_bad;
    logic [PEND_W-1:0] r_pend;
    logic [CODE_W-1:0] r_part;
    t_fmt              r_fmt;

    logic [PEND_W-1:0] n_pend;
    logic [CODE_W-1:0] n_part;
    logic [CODE_W-1:0] n_code;
    logic              n_bad;
    logic              emit;
    logic              out_free;
    logic              advance;
    logic [CODE_W-1:0] unit;
    logic [CODE_W-1:0] shifted;

    assign shifted = {r_part[CODE_W-7:0], 6'b0} | {8'h00, r_in_byte & CONT_MASK};

    always_comb begin
        n_pend = r_pend;
        n_part = r_part;
        unit   = '0;
        n_bad  = 1'b0;
        emit   = 1'b0;
        if (r_pend != PEND_NONE) begin
            n_pend = r_pend - PEND_ONE;
            if (n_pend != PEND_NONE) begin
                n_part = shifted;
            end else begin
                n_part = '0;
                unit   = shifted;
                emit   = 1'b1;
            end
        end else if (r_in_byte < 8'h80) begin
            unit = {8'h00, r_in_byte};
            emit = 1'b1;
        end else if (r_in_byte >= 8'hC0 && r_in_byte < 8'hE0) begin
            n_part = {8'h00, r_in_byte & LEAD2_MASK};
            n_pend = PEND_ONE;
        end else if (r_in_byte >= 8'hE0 && r_in_byte < 8'hF0) begin
            n_part = {8'h00, r_in_byte & LEAD3_MASK};
            n_pend = PEND_TWO;
        end else begin
            n_part = '0;
            n_pend = PEND_NONE;
            n_bad  = 1'b1;
            emit   = 1'b1;
        end
        if (n_bad) begin
            n_code = '0;
        end else if (r_fmt == FMT_CP1252) begin
            n_code = to_cp1252(unit);
        end else begin
            n_code = unit;
        end
    end

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!emit || out_free);
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in_byte <= i_in_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= PEND_NONE;
            r_part <= '0;
        end else if (advance) begin
            r_pend <= n_pend;
            r_part <= n_part;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && emit;
        end
        if (out_free && advance && emit) begin
            r_code <= n_code;
            r_bad  <= n_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt <= FMT_UTF16;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fmt <= t_fmt'(i_cfg_output_format);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_code_out  = r_code;
    assign o_bad_lead  = r_bad;

endmodule
